/* hw/rtl/udc_pkg.sv */
// shared types, key codes and register indexes for the up/down counter with key auto-repeat
package udc_pkg;

   localparam int DATA_BITS          = 16;
   localparam int TIMER_BITS         = 18;
   localparam int CSR_INDEX_BITS     = 8;
   localparam int COUNT_BITS_DEFAULT = 16;

   typedef enum logic [1:0] {
      KEY_NONE  = 2'd0,
      KEY_UP    = 2'd1,
      KEY_DOWN  = 2'd2,
      KEY_CLEAR = 2'd3
   } key_type;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_COUNT_LIMIT = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_COUNT = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_DELAY = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEXT_DELAY  = 8'd3;

   localparam logic [DATA_BITS-1:0] COUNT_LIMIT_RESET = 16'hFFFF;
   localparam logic [DATA_BITS-1:0] START_COUNT_RESET = 16'h0000;
   localparam logic [DATA_BITS-1:0] FIRST_DELAY_RESET = 16'h0000;
   localparam logic [DATA_BITS-1:0] NEXT_DELAY_RESET  = 16'h0000;

   typedef struct packed {
      logic [DATA_BITS-1:0] count_limit;
      logic [DATA_BITS-1:0] start_count;
      logic [DATA_BITS-1:0] first_delay;
      logic [DATA_BITS-1:0] next_delay;
   } cfg_type;

   typedef struct packed {
      logic                 up_key;
      logic                 down_key;
      logic                 clear_key;
      logic [DATA_BITS-1:0] elapsed_time;
   } tick_type;

endpackage

/* hw/rtl/updown_counter_autorepeat.sv */
// top level of the up/down counter with key auto-repeat
//
// Each req_ transaction is one update tick: up, down and clear key levels and
// the time elapsed since the previous tick. Every tick yields exactly one rsp_
// transaction carrying the clamped count and a nonzero flag, in tick order.
// Ticks go into an input register; the tick logic runs combinationally from
// that register into the result register and updates the counter state.
// rsp_valid rises after a tick moves from the input into the result register;
// throughput is one tick per cycle with rsp_ready high, set by the update loop.
// With rsp_ready low, one more tick is still taken into the input register,
// after which req_ready drops until the result register is drained.
// The csr_ port writes count_limit, start_count, first_delay and next_delay
// by index (csr_ready is always high); other indexes are ignored.
// Registers should be written only while no tick is in flight.
// Synchronous reset empties both stages, loads the register defaults, sets the
// count to zero, forgets the held key and zeroes the repeat timer.
module updown_counter_autorepeat #(
   parameter int COUNT_BITS = udc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_up_key,
   input  logic                               req_down_key,
   input  logic                               req_clear_key,
   input  logic [udc_pkg::DATA_BITS-1:0]      req_elapsed_time,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [udc_pkg::DATA_BITS-1:0]      rsp_count_out,
   output logic                               rsp_nonzero,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [udc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [udc_pkg::DATA_BITS-1:0]      csr_data
);

   localparam int EB = ((COUNT_BITS > udc_pkg::DATA_BITS) ? COUNT_BITS : udc_pkg::DATA_BITS);

   udc_pkg::cfg_type                 cfg_ff;
   udc_pkg::tick_type                tick_ff;
   logic                             tick_valid_ff;
   logic                             rsp_valid_ff;
   logic [udc_pkg::DATA_BITS-1:0]    rsp_count_out_ff;
   logic                             rsp_nonzero_ff;
   logic [COUNT_BITS-1:0]            count_ff;
   udc_pkg::key_type                 held_key_ff;
   logic [udc_pkg::TIMER_BITS-1:0]   repeat_timer_ff;

   logic [COUNT_BITS-1:0]            count_in;
   udc_pkg::key_type                 held_key_in;
   logic [udc_pkg::TIMER_BITS-1:0]   repeat_timer_in;
   logic [EB-1:0]                    count_ext;
   logic                             advance;
   logic                             req_take;

   assign advance   = tick_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !tick_valid_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_count_out = rsp_count_out_ff;
   assign rsp_nonzero   = rsp_nonzero_ff;

   udc_tick #(
      .COUNT_BITS(COUNT_BITS)
   ) u_tick (
      .cfg               (cfg_ff),
      .tick              (tick_ff),
      .count             (count_ff),
      .held_key          (held_key_ff),
      .repeat_timer      (repeat_timer_ff),
      .count_next        (count_in),
      .held_key_next     (held_key_in),
      .repeat_timer_next (repeat_timer_in)
   );

   assign count_ext = EB'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.count_limit <= udc_pkg::COUNT_LIMIT_RESET;
         cfg_ff.start_count <= udc_pkg::START_COUNT_RESET;
         cfg_ff.first_delay <= udc_pkg::FIRST_DELAY_RESET;
         cfg_ff.next_delay  <= udc_pkg::NEXT_DELAY_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            udc_pkg::CSR_COUNT_LIMIT: cfg_ff.count_limit <= csr_data;
            udc_pkg::CSR_START_COUNT: cfg_ff.start_count <= csr_data;
            udc_pkg::CSR_FIRST_DELAY: cfg_ff.first_delay <= csr_data;
            udc_pkg::CSR_NEXT_DELAY:  cfg_ff.next_delay  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         count_ff        <= '0;
         held_key_ff     <= udc_pkg::KEY_NONE;
         repeat_timer_ff <= '0;
      end else begin
         if (req_take) begin
            tick_valid_ff <= 1'b1;
         end else if (advance) begin
            tick_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff    <= 1'b1;
            count_ff        <= count_in;
            held_key_ff     <= held_key_in;
            repeat_timer_ff <= repeat_timer_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         tick_ff.up_key       <= req_up_key;
         tick_ff.down_key     <= req_down_key;
         tick_ff.clear_key    <= req_clear_key;
         tick_ff.elapsed_time <= req_elapsed_time;
      end
      if (advance) begin
         rsp_count_out_ff <= count_ext[udc_pkg::DATA_BITS-1:0];
         rsp_nonzero_ff   <= (count_in != '0);
      end
   end

endmodule

/* hw/rtl/udc_tick.sv */
// next-state logic for one tick: key tracking, repeat timer, step and clamp
module udc_tick #(
   parameter int COUNT_BITS = udc_pkg::COUNT_BITS_DEFAULT
) (
   input  udc_pkg::cfg_type                cfg,
   input  udc_pkg::tick_type               tick,
   input  logic [COUNT_BITS-1:0]           count,
   input  udc_pkg::key_type                held_key,
   input  logic [udc_pkg::TIMER_BITS-1:0]  repeat_timer,
   output logic [COUNT_BITS-1:0]           count_next,
   output udc_pkg::key_type                held_key_next,
   output logic [udc_pkg::TIMER_BITS-1:0]  repeat_timer_next
);

   localparam int VB = ((COUNT_BITS > udc_pkg::DATA_BITS) ? COUNT_BITS : udc_pkg::DATA_BITS) + 2;
   localparam int TB = udc_pkg::TIMER_BITS;
   localparam logic [VB-1:0] CAP = VB'((64'd1 << COUNT_BITS) - 64'd1);

   logic                 reinit;
   udc_pkg::key_type     held_eff;
   udc_pkg::key_type     step_code;
   logic signed [VB-1:0] base;
   logic signed [VB-1:0] start_ext;
   logic signed [VB-1:0] v;
   logic signed [VB-1:0] hi;
   logic [VB-1:0]        limit_ext;
   logic signed [TB:0]   t_wide;
   logic [TB-1:0]        t_sat;
   logic                 repeat_hit;
   logic                 step;

   assign reinit    = (tick.elapsed_time == '0);
   assign held_eff  = reinit ? udc_pkg::KEY_NONE : held_key;
   assign start_ext = $signed(VB'(cfg.start_count));
   assign base      = reinit ? start_ext : $signed(VB'(count));
   assign step_code = tick.up_key ? udc_pkg::KEY_UP : udc_pkg::KEY_DOWN;

   // timer drop with saturation at the 18-bit negative bound
   assign t_wide = $signed({repeat_timer[TB-1], repeat_timer})
                 - $signed({{(TB + 1 - udc_pkg::DATA_BITS){1'b0}}, tick.elapsed_time});
   assign t_sat  = (t_wide[TB:TB-1] == 2'b10) ? {1'b1, {(TB-1){1'b0}}} : t_wide[TB-1:0];
   assign repeat_hit = (cfg.first_delay != '0) && (t_sat[TB-1] || (t_sat == '0));

   assign limit_ext = VB'(cfg.count_limit);
   assign hi        = $signed((limit_ext < CAP) ? limit_ext : CAP);

   always_comb begin
      v                 = base;
      held_key_next     = held_eff;
      repeat_timer_next = repeat_timer;
      step              = 1'b0;
      if (tick.up_key || tick.down_key) begin
         if (held_eff == step_code) begin
            step = repeat_hit;
            repeat_timer_next = repeat_hit ? (t_sat + TB'(cfg.next_delay)) : t_sat;
         end else begin
            step = 1'b1;
            held_key_next = step_code;
            repeat_timer_next = TB'(cfg.first_delay);
         end
         if (tick.up_key) begin
            v = base + $signed(VB'(step));
         end else begin
            v = base - $signed(VB'(step));
         end
      end else if (tick.clear_key) begin
         v = start_ext;
         held_key_next = udc_pkg::KEY_CLEAR;
      end else begin
         held_key_next = udc_pkg::KEY_NONE;
      end
   end

   always_comb begin
      if (v[VB-1]) begin
         count_next = '0;
      end else if (v > hi) begin
         count_next = hi[COUNT_BITS-1:0];
      end else begin
         count_next = v[COUNT_BITS-1:0];
      end
   end

endmodule

/* tb/sv/updown_counter_autorepeat_tb.sv */
// self-checking testbench for the up/down counter with key auto-repeat
`timescale 1ns / 100ps

module updown_counter_autorepeat_tb;

   localparam int COUNT_W     = udc_pkg::COUNT_BITS_DEFAULT;
   localparam int DW          = udc_pkg::DATA_BITS;
   localparam int IW          = udc_pkg::CSR_INDEX_BITS;
   localparam int TIMER_FLOOR = -(1 << (udc_pkg::TIMER_BITS - 1));
   localparam int PHASE_TICKS = 100;
   localparam int RAND_PHASES = 8;

   typedef struct {
      udc_pkg::tick_type tick;
      logic              wait_drain;
   } tick_request_type;

   typedef struct packed {
      logic [DW-1:0] count_out;
      logic          nonzero;
   } count_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_up_key = 1'b0;
   logic                      req_down_key = 1'b0;
   logic                      req_clear_key = 1'b0;
   logic [DW-1:0]             req_elapsed_time = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [DW-1:0]             rsp_count_out;
   logic                      rsp_nonzero;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [IW-1:0]             csr_index = '0;
   logic [DW-1:0]             csr_data = '0;

   // counter model state and its copy of the registers
   udc_pkg::cfg_type     regs = '{udc_pkg::COUNT_LIMIT_RESET, udc_pkg::START_COUNT_RESET,
                                  udc_pkg::FIRST_DELAY_RESET, udc_pkg::NEXT_DELAY_RESET};
   logic [COUNT_W-1:0]   count_now = '0;
   udc_pkg::key_type     key_held = udc_pkg::KEY_NONE;
   int                   repeat_left = 0;

   tick_request_type     ticks_todo[$];
   count_result_type     counts_due[$];
   int                   mismatches = 0;
   logic                 calm = 1'b0;

   updown_counter_autorepeat #(.COUNT_BITS(COUNT_W)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_up_key       (req_up_key),
      .req_down_key     (req_down_key),
      .req_clear_key    (req_clear_key),
      .req_elapsed_time (req_elapsed_time),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_count_out    (rsp_count_out),
      .rsp_nonzero      (rsp_nonzero),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch at %0t: %s", $realtime, what);
      end
   endtask

   // step taken by a step key: fresh press steps at once, a held one on timer expiry
   function automatic int key_repeat_step(input udc_pkg::key_type code,
                                          input logic [DW-1:0] elapsed);
      int t;
      if (key_held != code) begin
         key_held    = code;
         repeat_left = int'(regs.first_delay);
         return 1;
      end
      t = repeat_left - int'(elapsed);
      if (t < TIMER_FLOOR) begin
         t = TIMER_FLOOR;
      end
      if (regs.first_delay != '0 && t <= 0) begin
         repeat_left = t + int'(regs.next_delay);
         return 1;
      end
      repeat_left = t;
      return 0;
   endfunction

   function automatic count_result_type count_after_tick(input udc_pkg::tick_type t);
      longint           v;
      longint           top;
      count_result_type r;
      v = longint'(count_now);
      if (t.elapsed_time == '0) begin
         key_held = udc_pkg::KEY_NONE;
         v        = longint'(regs.start_count);
      end
      if (t.up_key) begin
         v += key_repeat_step(udc_pkg::KEY_UP, t.elapsed_time);
      end else if (t.down_key) begin
         v -= key_repeat_step(udc_pkg::KEY_DOWN, t.elapsed_time);
      end else if (t.clear_key) begin
         v        = longint'(regs.start_count);
         key_held = udc_pkg::KEY_CLEAR;
      end else begin
         key_held = udc_pkg::KEY_NONE;
      end
      top = (longint'(1) << COUNT_W) - 1;
      if (longint'(regs.count_limit) < top) begin
         top = longint'(regs.count_limit);
      end
      if (v > top) begin
         v = top;
      end
      if (v < 0) begin
         v = 0;
      end
      count_now   = COUNT_W'(v);
      r.count_out = DW'(count_now);
      r.nonzero   = (count_now != '0);
      return r;
   endfunction

   function automatic logic [DW-1:0] pick_value();
      case ($urandom_range(5))
         0:       return '0;
         1:       return 16'd1;
         2:       return '1;
         3:       return DW'($urandom);
         default: return DW'($urandom_range(2, 24));
      endcase
   endfunction

   // tick driver
   always @(posedge clock) begin
      udc_pkg::tick_type seen;
      tick_request_type  nxt;
      logic              go;
      go = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            seen.up_key       = req_up_key;
            seen.down_key     = req_down_key;
            seen.clear_key    = req_clear_key;
            seen.elapsed_time = req_elapsed_time;
            counts_due.push_back(count_after_tick(seen));
         end
         if (!req_valid || req_ready) begin
            if (ticks_todo.size() != 0 && (calm || $urandom_range(99) >= 28)) begin
               if (!(ticks_todo[0].wait_drain && counts_due.size() != 0)) begin
                  nxt = ticks_todo.pop_front();
                  go  = 1'b1;
               end
            end
            req_valid <= go;
            if (go) begin
               req_up_key       <= nxt.tick.up_key;
               req_down_key     <= nxt.tick.down_key;
               req_clear_key    <= nxt.tick.clear_key;
               req_elapsed_time <= nxt.tick.elapsed_time;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      count_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (counts_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result count_out=%0d nonzero=%0b",
                                         rsp_count_out, rsp_nonzero));
            end else begin
               want = counts_due.pop_front();
               if (rsp_count_out !== want.count_out) begin
                  report_mismatch($sformatf("count_out expected %0d actual %0d",
                                            want.count_out, rsp_count_out));
               end
               if (rsp_nonzero !== want.nonzero) begin
                  report_mismatch($sformatf("nonzero expected %0b actual %0b",
                                            want.nonzero, rsp_nonzero));
               end
            end
         end
         rsp_ready <= calm || ($urandom_range(99) >= 28);
      end
   end

   task automatic queue_tick(input logic up, input logic down, input logic clr,
                             input logic [DW-1:0] elapsed,
                             input logic hold = 1'b0);
      tick_request_type r;
      r.tick.up_key       = up;
      r.tick.down_key     = down;
      r.tick.clear_key    = clr;
      r.tick.elapsed_time = elapsed;
      r.wait_drain        = hold;
      ticks_todo.push_back(r);
   endtask

   // wait until every queued tick is sent and every result has come back
   task automatic drain();
      do begin
         @(posedge clock);
         #1;
      end while (ticks_todo.size() != 0 || req_valid || counts_due.size() != 0);
   endtask

   // leaves csr_valid high; the caller lowers it after the last write
   task automatic write_reg(input logic [IW-1:0] idx,
                            input logic [DW-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock);
      while (!csr_ready);
      case (idx)
         udc_pkg::CSR_COUNT_LIMIT: regs.count_limit = val;
         udc_pkg::CSR_START_COUNT: regs.start_count = val;
         udc_pkg::CSR_FIRST_DELAY: regs.first_delay = val;
         udc_pkg::CSR_NEXT_DELAY:  regs.next_delay  = val;
         default: ;
      endcase
   endtask

   initial begin
      int   n;
      int   run;
      int   kind;
      int   k;
      int   r;
      logic up;
      logic down;
      logic clr;
      logic [DW-1:0] el;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: start above limit, clamps, priorities, reinitialize
      write_reg(udc_pkg::CSR_COUNT_LIMIT, 16'd5);
      write_reg(udc_pkg::CSR_START_COUNT, 16'd7);
      write_reg(udc_pkg::CSR_FIRST_DELAY, 16'd3);
      write_reg(udc_pkg::CSR_NEXT_DELAY, 16'd2);
      write_reg(IW'(4 + $urandom_range(251)), '1);
      csr_valid <= 1'b0;
      queue_tick(1'b0, 1'b0, 1'b0, 16'd0);
      queue_tick(1'b1, 1'b0, 1'b0, 16'd1);
      queue_tick(1'b1, 1'b0, 1'b0, 16'd1);
      queue_tick(1'b1, 1'b0, 1'b0, 16'd2);
      queue_tick(1'b0, 1'b1, 1'b0, 16'd1);
      queue_tick(1'b0, 1'b1, 1'b0, 16'hFFFF);
      queue_tick(1'b0, 1'b1, 1'b1, 16'd1);
      queue_tick(1'b0, 1'b1, 1'b0, 16'hFFFF);
      queue_tick(1'b0, 1'b1, 1'b0, 16'hFFFF);
      queue_tick(1'b0, 1'b1, 1'b0, 16'hFFFF);
      queue_tick(1'b1, 1'b1, 1'b1, 16'd1);
      queue_tick(1'b0, 1'b0, 1'b1, 16'd5);
      queue_tick(1'b0, 1'b0, 1'b1, 16'hFFFF);
      queue_tick(1'b1, 1'b0, 1'b0, 16'd0, 1'b1);
      queue_tick(1'b0, 1'b0, 1'b0, 16'd1);
      drain();

      // repeat disabled while up is held long: the timer bottoms out
      write_reg(udc_pkg::CSR_COUNT_LIMIT, '1);
      write_reg(udc_pkg::CSR_START_COUNT, '0);
      write_reg(udc_pkg::CSR_FIRST_DELAY, '0);
      csr_valid <= 1'b0;
      repeat (4) queue_tick(1'b1, 1'b0, 1'b0, 16'hFFFF);
      drain();
      write_reg(udc_pkg::CSR_FIRST_DELAY, 16'd1);
      write_reg(udc_pkg::CSR_NEXT_DELAY, '1);
      csr_valid <= 1'b0;
      queue_tick(1'b1, 1'b0, 1'b0, 16'd1);
      queue_tick(1'b1, 1'b0, 1'b0, 16'd1);
      queue_tick(1'b0, 1'b1, 1'b0, 16'd1);

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         drain();
         case (ph)
            0: begin
               write_reg(udc_pkg::CSR_COUNT_LIMIT, '1);
               write_reg(udc_pkg::CSR_START_COUNT, '1);
               write_reg(udc_pkg::CSR_FIRST_DELAY, 16'd1);
               write_reg(udc_pkg::CSR_NEXT_DELAY, '0);
            end
            1: begin
               write_reg(udc_pkg::CSR_COUNT_LIMIT, '0);
               write_reg(udc_pkg::CSR_START_COUNT, '0);
               write_reg(udc_pkg::CSR_FIRST_DELAY, '1);
               write_reg(udc_pkg::CSR_NEXT_DELAY, '1);
            end
            2: begin
               write_reg(udc_pkg::CSR_COUNT_LIMIT, 16'd20);
               write_reg(udc_pkg::CSR_START_COUNT, 16'd10);
               write_reg(udc_pkg::CSR_FIRST_DELAY, 16'd4);
               write_reg(udc_pkg::CSR_NEXT_DELAY, 16'd2);
            end
            default: begin
               write_reg(udc_pkg::CSR_COUNT_LIMIT, pick_value());
               write_reg(udc_pkg::CSR_START_COUNT, pick_value());
               write_reg(udc_pkg::CSR_FIRST_DELAY, pick_value());
               write_reg(udc_pkg::CSR_NEXT_DELAY, pick_value());
            end
         endcase
         if (ph % 3 == 1) begin
            write_reg(IW'(4 + $urandom_range(251)), DW'($urandom));
         end
         csr_valid <= 1'b0;
         calm = (ph == 4);

         // mostly key holds of random length, some noise and broken runs
         n = 0;
         while (n < PHASE_TICKS) begin
            run  = $urandom_range(1, 16);
            kind = $urandom_range(9);
            for (k = 0; k < run && n < PHASE_TICKS; k++) begin
               up   = (kind <= 2);
               down = (kind >= 3 && kind <= 5);
               clr  = (kind == 6);
               if (kind >= 8 || $urandom_range(9) == 0) begin
                  up   = 1'($urandom_range(1));
                  down = 1'($urandom_range(1));
                  clr  = 1'($urandom_range(1));
               end
               r = $urandom_range(99);
               if (r < 3) begin
                  el = '0;
               end else if (r < 8) begin
                  el = '1;
               end else if (r < 20) begin
                  el = DW'($urandom);
               end else begin
                  el = DW'($urandom_range(1, 6));
               end
               queue_tick(up, down, clr, el, $urandom_range(199) == 0);
               n++;
            end
         end
      end
      drain();
      calm = 1'b0;

      repeat (8) @(posedge clock);
      if (counts_due.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", counts_due.size()));
      end
      if (mismatches == 0) begin
         $display("updown_counter_autorepeat regression: pass");
      end else begin
         $display("updown_counter_autorepeat regression: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("updown_counter_autorepeat regression: fail");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/udc_pkg.sv
hw/rtl/udc_tick.sv
hw/rtl/updown_counter_autorepeat.sv
tb/sv/updown_counter_autorepeat_tb.sv
